// ----- rtl/bsr_pkg.sv -----
// Shared constants and types of the byte stream reassembler.
package bsr_pkg;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 64;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 7;
  localparam int WINDOW_DEF = 64;

  localparam logic [CNT_W-1:0] CAP_RST = 7'd64;

  localparam logic [CMD_W-1:0] CMD_DATA = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LAST = 2'd2;

  typedef enum logic [1:0] {
    ALU_SUB = 2'd0,
    ALU_INC = 2'd1,
    ALU_CMP = 2'd2
  } alu_op_t;

endpackage

// ----- rtl/bsr_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface bsr_in_if import bsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] data_byte;
  logic              is_final;
  logic [CNT_W-1:0]  pop_count;

  modport source (output valid, cmd, byte_index, data_byte, is_final, pop_count,
                  input ready);
  modport sink (input valid, cmd, byte_index, data_byte, is_final, pop_count,
                output ready);
endinterface

interface bsr_out_if import bsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              byte_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              stream_closed;
  logic [CNT_W-1:0]  pending_count;
  logic [CNT_W-1:0]  stream_fill;
  logic              last_of_run;

  modport source (output valid, byte_valid, out_byte, stream_closed, pending_count,
                  stream_fill, last_of_run, input ready);
  modport sink (input valid, byte_valid, out_byte, stream_closed, pending_count,
                stream_fill, last_of_run, output ready);
endinterface

// ----- rtl/bsr_alu.sv -----
// Shared 64-bit adder used for window offset, end-index compare and index increment.
module bsr_alu import bsr_pkg::*; (
  input  alu_op_t          op,
  input  logic [IDX_W-1:0] a,
  input  logic [IDX_W-1:0] b,
  output logic [IDX_W-1:0] res,
  output logic             zero
);

  logic [IDX_W-1:0] b_eff;

  always_comb begin
    case (op)
      ALU_SUB: b_eff = ~b;
      ALU_CMP: b_eff = ~b;
      ALU_INC: b_eff = '0;
      default: b_eff = ~b;
    endcase
  end

  assign res  = a + b_eff + IDX_W'(1);
  assign zero = (res == '0);

endmodule

// ----- rtl/bsr_hold_mem.sv -----
// Ring store for bytes held out of order, one write port and one registered read port.
module bsr_hold_mem import bsr_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  parameter int AW     = $clog2(WINDOW)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/byte_stream_reassembler_top.sv -----
// Byte stream reassembler: top level with sequencer, state registers and result register.
//
// Bytes arrive with absolute 64-bit stream indexes and leave in order. A byte is taken when its
// index lies in the window from the next expected index up to the free output capacity; later
// bytes wait in a ring store with valid marks, and an in-order byte is followed by the held run
// behind it. One item is handled at a time and in_ch.ready is high only while the block is idle.
// Pop, empty-last and unused commands, and data bytes that arrive after the output has closed,
// pass through EXEC, LOAD and OUT; a data byte that is stored or falls outside the window adds
// CHECK, and an in-order byte runs EXEC, CHECK, READ, EMIT, ADV, LOAD and OUT, then READ to OUT
// again for every held byte drained after it. The steps come from one shared 64-bit adder that
// forms the window offset, the end-index compare and the index increment in separate steps,
// from the registered ring store read port and the single result register. Each item gives one
// or more result items, the last with last_of_run set. There is no clearing pass after reset.
module byte_stream_reassembler_top import bsr_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bsr_in_if.sink           in_ch,
  bsr_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(WINDOW);
  localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
  localparam logic [AW:0]      WIN_SUM = (AW+1)'(WINDOW);
  localparam logic [AW-1:0]    WIN_TOP = AW'(WINDOW - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_EMIT  = 8'b0001_0000,
    S_ADV   = 8'b0010_0000,
    S_LOAD  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cap_r;
  logic [IDX_W-1:0]  ne_r, ne_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [WINDOW-1:0] hv_r, hv_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              end_known_r, end_known_nxt;
  logic [IDX_W-1:0]  end_idx_r, end_idx_nxt;
  logic              closed_r, closed_nxt;

  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              fin_r, fin_nxt;
  logic [CNT_W-1:0]  pop_r, pop_nxt;
  logic [IDX_W-1:0]  off_r, off_nxt;
  logic              eq_r, eq_nxt;
  logic              from_mem_r, from_mem_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              bv_r, bv_nxt;
  logic              more_r, more_nxt;

  logic              ov_r, ov_nxt;
  logic              obv_r, obv_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              oclosed_r, oclosed_nxt;
  logic [CNT_W-1:0]  oheld_r, oheld_nxt;
  logic [CNT_W-1:0]  ofill_r, ofill_nxt;
  logic              olast_r, olast_nxt;

  alu_op_t           alu_op;
  logic [IDX_W-1:0]  alu_a, alu_b, alu_res;
  logic              alu_zero;

  logic              mem_we;
  logic [AW-1:0]     slot;
  logic [AW:0]       slot_sum;
  logic [BYTE_W-1:0] mem_rdata;

  logic [CNT_W-1:0]  eff_cap, avail;
  logic              in_win, more;

  bsr_alu u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .zero (alu_zero)
  );

  bsr_hold_mem #(.WINDOW(WINDOW), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata (data_r),
    .raddr (head_r),
    .rdata (mem_rdata)
  );

  assign eff_cap  = (cap_r > WIN_CNT) ? WIN_CNT : cap_r;
  assign avail    = (fill_r >= eff_cap) ? '0 : eff_cap - fill_r;
  assign in_win   = (off_r[IDX_W-1:CNT_W] == '0) && (off_r[CNT_W-1:0] < avail);
  assign slot_sum = {1'b0, head_r} + {1'b0, off_r[AW-1:0]};
  assign slot     = (slot_sum >= WIN_SUM) ? AW'(slot_sum - WIN_SUM) : slot_sum[AW-1:0];
  assign more     = !closed_r && (fill_r < eff_cap) && hv_r[head_r];

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.byte_valid    = obv_r;
  assign out_ch.out_byte      = obyte_r;
  assign out_ch.stream_closed = oclosed_r;
  assign out_ch.pending_count = oheld_r;
  assign out_ch.stream_fill   = ofill_r;
  assign out_ch.last_of_run   = olast_r;

  always_comb begin
    state_nxt     = state_r;
    ne_nxt        = ne_r;
    head_nxt      = head_r;
    hv_nxt        = hv_r;
    held_nxt      = held_r;
    fill_nxt      = fill_r;
    end_known_nxt = end_known_r;
    end_idx_nxt   = end_idx_r;
    closed_nxt    = closed_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    data_nxt      = data_r;
    fin_nxt       = fin_r;
    pop_nxt       = pop_r;
    off_nxt       = off_r;
    eq_nxt        = eq_r;
    from_mem_nxt  = from_mem_r;
    byte_nxt      = byte_r;
    bv_nxt        = bv_r;
    more_nxt      = more_r;
    ov_nxt        = ov_r;
    obv_nxt       = obv_r;
    obyte_nxt     = obyte_r;
    oclosed_nxt   = oclosed_r;
    oheld_nxt     = oheld_r;
    ofill_nxt     = ofill_r;
    olast_nxt     = olast_r;
    alu_op        = ALU_SUB;
    alu_a         = idx_r;
    alu_b         = ne_r;
    mem_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          idx_nxt   = in_ch.byte_index;
          data_nxt  = in_ch.data_byte;
          fin_nxt   = in_ch.is_final;
          pop_nxt   = in_ch.pop_count;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        bv_nxt    = 1'b0;
        state_nxt = S_LOAD;
        case (cmd_r)
          CMD_POP: begin
            fill_nxt = fill_r - ((pop_r < fill_r) ? pop_r : fill_r);
          end
          CMD_LAST: begin
            closed_nxt = 1'b1;
          end
          CMD_DATA: begin
            if (!closed_r) begin
              off_nxt   = alu_res;
              state_nxt = S_CHECK;
            end
          end
          default: begin
            state_nxt = S_LOAD;
          end
        endcase
      end
      S_CHECK: begin
        state_nxt = S_LOAD;
        if (in_win) begin
          if (off_r == '0) begin
            state_nxt = S_READ;
          end else begin
            if (!hv_r[slot]) begin
              mem_we       = 1'b1;
              hv_nxt[slot] = 1'b1;
              held_nxt     = held_r + CNT_W'(1);
            end
            if (fin_r && !end_known_r) begin
              end_known_nxt = 1'b1;
              end_idx_nxt   = idx_r;
            end
          end
        end
      end
      S_READ: begin
        from_mem_nxt = hv_r[head_r];
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        alu_op   = ALU_CMP;
        alu_a    = ne_r;
        alu_b    = end_idx_r;
        eq_nxt   = alu_zero;
        byte_nxt = from_mem_r ? mem_rdata : data_r;
        if (from_mem_r) begin
          hv_nxt[head_r] = 1'b0;
          held_nxt       = held_r - CNT_W'(1);
        end
        state_nxt = S_ADV;
      end
      S_ADV: begin
        alu_op   = ALU_INC;
        alu_a    = ne_r;
        ne_nxt   = alu_res;
        head_nxt = (head_r == WIN_TOP) ? '0 : head_r + AW'(1);
        fill_nxt = fill_r + CNT_W'(1);
        if (fin_r || (end_known_r && eq_r)) begin
          closed_nxt = 1'b1;
        end
        fin_nxt   = 1'b0;
        bv_nxt    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        ov_nxt      = 1'b1;
        obv_nxt     = bv_r;
        obyte_nxt   = bv_r ? byte_r : '0;
        oclosed_nxt = closed_r;
        oheld_nxt   = held_r;
        ofill_nxt   = fill_r;
        more_nxt    = bv_r && more;
        olast_nxt   = !(bv_r && more);
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          ov_nxt    = 1'b0;
          state_nxt = more_r ? S_READ : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RST;
      ne_r        <= '0;
      head_r      <= '0;
      hv_r        <= '0;
      held_r      <= '0;
      fill_r      <= '0;
      end_known_r <= 1'b0;
      end_idx_r   <= '0;
      closed_r    <= 1'b0;
      ov_r        <= 1'b0;
      more_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      ne_r        <= ne_nxt;
      head_r      <= head_nxt;
      hv_r        <= hv_nxt;
      held_r      <= held_nxt;
      fill_r      <= fill_nxt;
      end_known_r <= end_known_nxt;
      end_idx_r   <= end_idx_nxt;
      closed_r    <= closed_nxt;
      ov_r        <= ov_nxt;
      more_r      <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    data_r     <= data_nxt;
    fin_r      <= fin_nxt;
    pop_r      <= pop_nxt;
    off_r      <= off_nxt;
    eq_r       <= eq_nxt;
    from_mem_r <= from_mem_nxt;
    byte_r     <= byte_nxt;
    bv_r       <= bv_nxt;
    obv_r      <= obv_nxt;
    obyte_r    <= obyte_nxt;
    oclosed_r  <= oclosed_nxt;
    oheld_r    <= oheld_nxt;
    ofill_r    <= ofill_nxt;
    olast_r    <= olast_nxt;
  end

`ifndef ASSERT_OFF
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result item is pending");

  a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == CNT_W'($countones(hv_r)))
    else $error("held byte count differs from valid marks");

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r)
    else $error("closed output reopened");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_CNT)
    else $error("output fill exceeds the window");
`endif

endmodule
